@@ rtl/core/rfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rfd_pkg: record frame decoder shared definitions
// Header layout offsets, phase, status and register codes, result record, CRC-32C byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  localparam int HDR_SIZE     = 28;
  localparam int HCRC_SPAN    = 24;
  localparam int OFS_MAGIC    = 0;
  localparam int OFS_VER      = 4;
  localparam int OFS_TYPE     = 6;
  localparam int OFS_LEN      = 8;
  localparam int OFS_SEQ      = 12;
  localparam int OFS_PCRC     = 20;
  localparam int OFS_HCRC     = 24;

  localparam int IDX_W   = 5;
  localparam int OUT_W   = 128;
  localparam int NUM_TYPES = 16;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DROP    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_MORE   = 3'd1,
    ST_TORN      = 3'd2,
    ST_CORRUPT   = 3'd3,
    ST_VERSION   = 3'd4,
    ST_TYPE      = 3'd5,
    ST_OVERSIZED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_MAGIC   = 2'd0,
    REG_VERSION = 2'd1,
    REG_TYPES   = 2'd2,
    REG_MAXLEN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] decl_len;
    logic [63:0] sequence_number;
    logic [15:0] record_type;
    status_t     status;
    logic [7:0]  payload_byte;
  } result_t;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/record_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// record_frame_decoder: length-prefixed record parser with CRC-32C checks
// Parses 28-byte headers, checks them, passes payload bytes and reports status.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one beat per stream byte: tuser 0 with the byte in tdata,
//   tuser 1 marks end of available data. m_axis carries at most one result
//   beat per input beat: payload bytes (tuser high) and the final status of
//   a record (tlast high). Dropped beats give no result, nor do header beats
//   but the last of a header that fails or has no payload. While m_axis does
//   not stall, one beat per cycle goes through a single stage to the result
//   register; the CRC-32C byte update and the header checks sit in that stage.
//   When m_axis stalls with a result held, s_axis tready drops until the
//   result is taken. Reset returns the parser to record start and restores
//   the register defaults (magic 0, version 1, all types 0-15 valid, no
//   length limit). Write cfg only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module record_frame_decoder (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [26:11] record_type,
  // [90:27] sequence_number, [122:91] declared length, [127:123] zero
  output logic [127:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // [0] payload_valid
  output logic              m_axis_tlast    // record_done
);

  localparam int HB = rfd_pkg::HDR_SIZE;

  logic [31:0] magic_word;
  logic [15:0] format_version;
  logic [15:0] valid_type_mask;
  logic [31:0] max_payload_len;

  rfd_pkg::phase_t phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] crc_running, crc_running_next;
  logic [7:0]  header_store [HB];

  logic            out_valid;
  logic            out_pvalid;
  logic            out_done;
  rfd_pkg::result_t out_res;

  logic             acc;
  logic             is_end;
  logic [7:0]       b;
  logic [rfd_pkg::IDX_W-1:0] idx;
  logic             hdr_last;
  logic             hdr_write;
  logic [31:0]      crc_base, crc_hdr, crc_pay;
  logic [31:0]      cnt_inc;
  logic [31:0]      f_magic, f_len, f_pcrc, f_hcrc;
  logic [15:0]      f_ver, f_type;
  logic [63:0]      f_seq;
  rfd_pkg::status_t hdr_status;
  logic             pay_last;

  logic             res_valid;
  logic             res_pvalid;
  logic             res_done;
  logic             res_hdr;
  rfd_pkg::status_t res_status;

  assign acc    = s_axis_tvalid && s_axis_tready;
  assign is_end = s_axis_tuser;
  assign b      = s_axis_tdata;

  assign s_axis_tready = !out_valid || m_axis_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word      <= 32'd0;
      format_version  <= 16'd1;
      valid_type_mask <= 16'hFFFF;
      max_payload_len <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (rfd_pkg::reg_idx_t'(cfg_index))
        rfd_pkg::REG_MAGIC:   magic_word      <= cfg_data;
        rfd_pkg::REG_VERSION: format_version  <= cfg_data[15:0];
        rfd_pkg::REG_TYPES:   valid_type_mask <= cfg_data[15:0];
        rfd_pkg::REG_MAXLEN:  max_payload_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // header field views
  assign f_magic = {header_store[rfd_pkg::OFS_MAGIC+3], header_store[rfd_pkg::OFS_MAGIC+2],
                    header_store[rfd_pkg::OFS_MAGIC+1], header_store[rfd_pkg::OFS_MAGIC]};
  assign f_ver   = {header_store[rfd_pkg::OFS_VER+1], header_store[rfd_pkg::OFS_VER]};
  assign f_type  = {header_store[rfd_pkg::OFS_TYPE+1], header_store[rfd_pkg::OFS_TYPE]};
  assign f_len   = {header_store[rfd_pkg::OFS_LEN+3], header_store[rfd_pkg::OFS_LEN+2],
                    header_store[rfd_pkg::OFS_LEN+1], header_store[rfd_pkg::OFS_LEN]};
  assign f_seq   = {header_store[rfd_pkg::OFS_SEQ+7], header_store[rfd_pkg::OFS_SEQ+6],
                    header_store[rfd_pkg::OFS_SEQ+5], header_store[rfd_pkg::OFS_SEQ+4],
                    header_store[rfd_pkg::OFS_SEQ+3], header_store[rfd_pkg::OFS_SEQ+2],
                    header_store[rfd_pkg::OFS_SEQ+1], header_store[rfd_pkg::OFS_SEQ]};
  assign f_pcrc  = {header_store[rfd_pkg::OFS_PCRC+3], header_store[rfd_pkg::OFS_PCRC+2],
                    header_store[rfd_pkg::OFS_PCRC+1], header_store[rfd_pkg::OFS_PCRC]};
  // last header byte arrives in this beat
  assign f_hcrc  = {b, header_store[rfd_pkg::OFS_HCRC+2], header_store[rfd_pkg::OFS_HCRC+1],
                    header_store[rfd_pkg::OFS_HCRC]};

  assign idx       = (phase == rfd_pkg::PH_IDLE) ? '0 : byte_count[rfd_pkg::IDX_W-1:0];
  assign hdr_last  = (idx == rfd_pkg::IDX_W'(HB - 1));
  assign crc_base  = (idx == '0) ? rfd_pkg::CRC_INIT : crc_running;
  assign crc_hdr   = (idx < rfd_pkg::IDX_W'(rfd_pkg::HCRC_SPAN)) ?
                     rfd_pkg::crc32c_byte(crc_base, b) : crc_base;
  assign crc_pay   = rfd_pkg::crc32c_byte(crc_running, b);
  assign cnt_inc   = byte_count + 32'd1;
  assign pay_last  = (cnt_inc >= f_len);
  assign hdr_write = acc && !is_end &&
                     (phase == rfd_pkg::PH_IDLE || phase == rfd_pkg::PH_HEADER);

  always_comb begin
    if (f_magic != magic_word) begin
      hdr_status = rfd_pkg::ST_CORRUPT;
    end else if (f_ver != format_version) begin
      hdr_status = rfd_pkg::ST_VERSION;
    end else if ((f_type >= 16'(rfd_pkg::NUM_TYPES)) || !valid_type_mask[f_type[3:0]]) begin
      hdr_status = rfd_pkg::ST_TYPE;
    end else if (f_len > max_payload_len) begin
      hdr_status = rfd_pkg::ST_OVERSIZED;
    end else if (~crc_hdr != f_hcrc) begin
      hdr_status = rfd_pkg::ST_CORRUPT;
    end else begin
      hdr_status = rfd_pkg::ST_OK;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (is_end) begin
      phase_next = rfd_pkg::PH_IDLE;
    end else begin
      case (phase)
        rfd_pkg::PH_IDLE, rfd_pkg::PH_HEADER: begin
          if (!hdr_last) begin
            phase_next = rfd_pkg::PH_HEADER;
          end else if (hdr_status != rfd_pkg::ST_OK) begin
            phase_next = rfd_pkg::PH_DROP;
          end else if (f_len == 32'd0) begin
            phase_next = rfd_pkg::PH_IDLE;
          end else begin
            phase_next = rfd_pkg::PH_PAYLOAD;
          end
        end
        rfd_pkg::PH_PAYLOAD: begin
          if (pay_last) phase_next = rfd_pkg::PH_IDLE;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // counters, crc and result
  always_comb begin
    byte_count_next  = byte_count;
    crc_running_next = crc_running;
    res_valid  = 1'b0;
    res_pvalid = 1'b0;
    res_done   = 1'b0;
    res_hdr    = 1'b0;
    res_status = rfd_pkg::ST_OK;
    if (is_end) begin
      byte_count_next  = 32'd0;
      crc_running_next = rfd_pkg::CRC_INIT;
      res_done = 1'b1;
      case (phase)
        rfd_pkg::PH_IDLE: begin
          res_valid  = 1'b1;
          res_status = rfd_pkg::ST_NO_MORE;
        end
        rfd_pkg::PH_HEADER: begin
          res_valid  = 1'b1;
          res_status = rfd_pkg::ST_TORN;
        end
        rfd_pkg::PH_PAYLOAD: begin
          res_valid  = 1'b1;
          res_hdr    = 1'b1;
          res_status = rfd_pkg::ST_TORN;
        end
        default: res_valid = 1'b0;
      endcase
    end else begin
      case (phase)
        rfd_pkg::PH_IDLE, rfd_pkg::PH_HEADER: begin
          crc_running_next = crc_hdr;
          byte_count_next  = 32'(idx) + 32'd1;
          if (hdr_last) begin
            byte_count_next  = 32'd0;
            crc_running_next = rfd_pkg::CRC_INIT;
            if (hdr_status != rfd_pkg::ST_OK) begin
              res_valid  = 1'b1;
              res_done   = 1'b1;
              res_hdr    = 1'b1;
              res_status = hdr_status;
            end else if (f_len == 32'd0) begin
              res_valid  = 1'b1;
              res_done   = 1'b1;
              res_hdr    = 1'b1;
              res_status = (f_pcrc == 32'd0) ? rfd_pkg::ST_OK : rfd_pkg::ST_CORRUPT;
            end
          end
        end
        rfd_pkg::PH_PAYLOAD: begin
          res_valid  = 1'b1;
          res_pvalid = 1'b1;
          res_hdr    = 1'b1;
          crc_running_next = crc_pay;
          byte_count_next  = cnt_inc;
          if (pay_last) begin
            res_done   = 1'b1;
            res_status = (~crc_pay == f_pcrc) ? rfd_pkg::ST_OK : rfd_pkg::ST_CORRUPT;
            byte_count_next  = 32'd0;
            crc_running_next = rfd_pkg::CRC_INIT;
          end
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rfd_pkg::PH_IDLE;
      byte_count  <= 32'd0;
      crc_running <= rfd_pkg::CRC_INIT;
    end else if (acc) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      crc_running <= crc_running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_write) header_store[idx] <= b;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      out_pvalid                <= res_pvalid;
      out_done                  <= res_done;
      out_res.payload_byte      <= res_pvalid ? b : 8'd0;
      out_res.status            <= res_status;
      out_res.record_type       <= res_hdr ? f_type : 16'd0;
      out_res.sequence_number   <= res_hdr ? f_seq : 64'd0;
      out_res.decl_len          <= res_hdr ? f_len : 32'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_pvalid;
  assign m_axis_tlast  = out_done;
  assign m_axis_tdata  = {(rfd_pkg::OUT_W - $bits(rfd_pkg::result_t))'(0), out_res};

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: record frame decoder testbench
// Streams records with random payloads, damaged headers, torn tails and noise
// through the decoder under random sender gaps and receiver stalls. Each beat
// accepted on s_axis is decoded by a cycle-free predictor and every m_axis
// beat is compared field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [7:0]       pbyte;
    logic             pvalid;
    logic             done;
    rfd_pkg::status_t st;
    logic [15:0]      rtype;
    logic [63:0]      seq;
    logic [31:0]      plen;
  } record_beat_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
  } stream_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  rfd_pkg::reg_idx_t cfg_index = rfd_pkg::REG_MAGIC;
  logic [31:0]       cfg_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [127:0]      m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  stream_beat_t stream_beats [$];
  record_beat_t decoded_beats [$];
  stream_beat_t nxt;
  int unsigned  beats_queued = 0;
  int unsigned  mismatches = 0;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  mode_left = 0;
  int unsigned  tick = 0;

  logic [31:0]  cfg_magic = 32'h0;
  logic [15:0]  cfg_version = 16'd1;
  logic [15:0]  cfg_types = 16'hFFFF;
  logic [31:0]  cfg_maxlen = 32'hFFFF_FFFF;

  rfd_pkg::phase_t ph;
  logic [31:0]     hdr_count;
  logic [7:0]      hdr_bytes [rfd_pkg::HDR_SIZE];
  logic [31:0]     crc_acc;

  record_frame_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #4_800_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] crc32c_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    repeat (8) c = (c >> 1) ^ (c[0] ? rfd_pkg::CRC_POLY : 32'h0);
    return c;
  endfunction

  function automatic logic [63:0] hdr_le(input int ofs, input int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 64'(hdr_bytes[ofs + i]) << (8 * i);
    return v;
  endfunction

  function automatic record_beat_t make_beat(input logic [7:0] pb, input logic pv,
                                             input logic dn, input rfd_pkg::status_t st,
                                             input bit with_hdr);
    record_beat_t r;
    r = '0;
    r.pbyte = pb;
    r.pvalid = pv;
    r.done = dn;
    r.st = st;
    if (with_hdr) begin
      r.rtype = 16'(hdr_le(rfd_pkg::OFS_TYPE, 2));
      r.seq = hdr_le(rfd_pkg::OFS_SEQ, 8);
      r.plen = 32'(hdr_le(rfd_pkg::OFS_LEN, 4));
    end
    return r;
  endfunction

  function automatic rfd_pkg::status_t header_verdict();
    logic [15:0] t;
    t = 16'(hdr_le(rfd_pkg::OFS_TYPE, 2));
    if (32'(hdr_le(rfd_pkg::OFS_MAGIC, 4)) != cfg_magic) return rfd_pkg::ST_CORRUPT;
    if (16'(hdr_le(rfd_pkg::OFS_VER, 2)) != cfg_version) return rfd_pkg::ST_VERSION;
    if (t >= 16'(rfd_pkg::NUM_TYPES) || !cfg_types[t[3:0]]) return rfd_pkg::ST_TYPE;
    if (32'(hdr_le(rfd_pkg::OFS_LEN, 4)) > cfg_maxlen) return rfd_pkg::ST_OVERSIZED;
    if ((crc_acc ^ rfd_pkg::CRC_INIT) != 32'(hdr_le(rfd_pkg::OFS_HCRC, 4)))
      return rfd_pkg::ST_CORRUPT;
    return rfd_pkg::ST_OK;
  endfunction

  task automatic queue_result(input record_beat_t r);
    decoded_beats.insert(decoded_beats.size(), r);
  endtask

  task automatic decode_beat(input logic kind, input logic [7:0] b);
    rfd_pkg::phase_t  prev;
    logic [31:0]      idx;
    rfd_pkg::status_t st;
    if (kind) begin
      prev = ph;
      ph = rfd_pkg::PH_IDLE;
      hdr_count = 32'd0;
      crc_acc = rfd_pkg::CRC_INIT;
      case (prev)
        rfd_pkg::PH_IDLE:
          queue_result(make_beat(8'h0, 1'b0, 1'b1, rfd_pkg::ST_NO_MORE, 1'b0));
        rfd_pkg::PH_HEADER:
          queue_result(make_beat(8'h0, 1'b0, 1'b1, rfd_pkg::ST_TORN, 1'b0));
        rfd_pkg::PH_PAYLOAD:
          queue_result(make_beat(8'h0, 1'b0, 1'b1, rfd_pkg::ST_TORN, 1'b1));
        default: ;
      endcase
    end else if (ph == rfd_pkg::PH_IDLE || ph == rfd_pkg::PH_HEADER) begin
      idx = (ph == rfd_pkg::PH_IDLE) ? 32'd0 : hdr_count;
      if (idx >= 32'(rfd_pkg::HDR_SIZE)) idx = 32'd0;
      if (idx == 32'd0) crc_acc = rfd_pkg::CRC_INIT;
      hdr_bytes[idx[4:0]] = b;
      if (idx < 32'(rfd_pkg::HCRC_SPAN)) crc_acc = crc32c_next(crc_acc, b);
      hdr_count = idx + 32'd1;
      ph = rfd_pkg::PH_HEADER;
      if (hdr_count == 32'(rfd_pkg::HDR_SIZE)) begin
        st = header_verdict();
        hdr_count = 32'd0;
        crc_acc = rfd_pkg::CRC_INIT;
        if (st != rfd_pkg::ST_OK) begin
          ph = rfd_pkg::PH_DROP;
          queue_result(make_beat(8'h0, 1'b0, 1'b1, st, 1'b1));
        end else if (hdr_le(rfd_pkg::OFS_LEN, 4) == 64'd0) begin
          ph = rfd_pkg::PH_IDLE;
          st = (hdr_le(rfd_pkg::OFS_PCRC, 4) == 64'd0) ? rfd_pkg::ST_OK : rfd_pkg::ST_CORRUPT;
          queue_result(make_beat(8'h0, 1'b0, 1'b1, st, 1'b1));
        end else begin
          ph = rfd_pkg::PH_PAYLOAD;
        end
      end
    end else if (ph == rfd_pkg::PH_PAYLOAD) begin
      crc_acc = crc32c_next(crc_acc, b);
      hdr_count = hdr_count + 32'd1;
      if (hdr_count >= 32'(hdr_le(rfd_pkg::OFS_LEN, 4))) begin
        st = ((crc_acc ^ rfd_pkg::CRC_INIT) == 32'(hdr_le(rfd_pkg::OFS_PCRC, 4))) ?
             rfd_pkg::ST_OK : rfd_pkg::ST_CORRUPT;
        queue_result(make_beat(b, 1'b1, 1'b1, st, 1'b1));
        ph = rfd_pkg::PH_IDLE;
        hdr_count = 32'd0;
        crc_acc = rfd_pkg::CRC_INIT;
      end else begin
        queue_result(make_beat(b, 1'b1, 1'b0, rfd_pkg::ST_OK, 1'b1));
      end
    end
  endtask

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    if (mismatches < 50)
      $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    rfd_pkg::result_t got;
    record_beat_t     want;
    got = m_axis_tdata[122:0];
    if (decoded_beats.size() == 0) begin
      report("result beat with none pending", m_axis_tdata, 128'd0);
      return;
    end
    want = decoded_beats.pop_front();
    if (got.payload_byte != want.pbyte)
      report("payload_byte", 128'(got.payload_byte), 128'(want.pbyte));
    if (m_axis_tuser != want.pvalid)
      report("payload_valid", 128'(m_axis_tuser), 128'(want.pvalid));
    if (m_axis_tlast != want.done)
      report("record_done", 128'(m_axis_tlast), 128'(want.done));
    if (got.status != want.st) report("status", 128'(got.status), 128'(want.st));
    if (got.record_type != want.rtype)
      report("record_type", 128'(got.record_type), 128'(want.rtype));
    if (got.sequence_number != want.seq)
      report("sequence_number", 128'(got.sequence_number), 128'(want.seq));
    if (got.decl_len != want.plen)
      report("declared length", 128'(got.decl_len), 128'(want.plen));
    if (m_axis_tdata[127:123] != 5'd0)
      report("tdata pad bits", 128'(m_axis_tdata[127:123]), 128'd0);
  endtask

  // sender: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      ph = rfd_pkg::PH_IDLE;
      hdr_count = 32'd0;
      crc_acc = rfd_pkg::CRC_INIT;
      foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_beat(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (stream_beats.size() != 0) begin
          nxt = stream_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nxt.kind;
          s_axis_tdata <= nxt.data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches among four random modes
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      mode_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      tick <= tick + 1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= (tick % 3 == 0);
        default: m_axis_tready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  task automatic push_beat(input logic kind, input logic [7:0] data);
    stream_beat_t s;
    s.kind = kind;
    s.data = data;
    stream_beats.insert(stream_beats.size(), s);
    beats_queued++;
  endtask

  task automatic push_end();
    push_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_record(input logic [31:0] magic, input logic [15:0] ver,
                             input logic [15:0] rtype, input logic [31:0] plen,
                             input logic [63:0] seq, input bit pcrc_bad, input bit hcrc_bad,
                             input int unsigned sent);
    logic [7:0]  hb [rfd_pkg::HDR_SIZE];
    logic [7:0]  body [$];
    logic [31:0] pcrc;
    logic [31:0] hcrc;
    pcrc = rfd_pkg::CRC_INIT;
    for (int i = 0; i < int'(sent) - rfd_pkg::HDR_SIZE; i++) begin
      body.insert(body.size(), 8'($urandom_range(0, 255)));
      pcrc = crc32c_next(pcrc, body[i]);
    end
    pcrc ^= rfd_pkg::CRC_INIT;
    if (pcrc_bad) pcrc ^= 32'd1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) begin
      hb[rfd_pkg::OFS_MAGIC + i] = magic[8*i +: 8];
      hb[rfd_pkg::OFS_LEN + i] = plen[8*i +: 8];
      hb[rfd_pkg::OFS_PCRC + i] = pcrc[8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      hb[rfd_pkg::OFS_VER + i] = ver[8*i +: 8];
      hb[rfd_pkg::OFS_TYPE + i] = rtype[8*i +: 8];
    end
    for (int i = 0; i < 8; i++) hb[rfd_pkg::OFS_SEQ + i] = seq[8*i +: 8];
    hcrc = rfd_pkg::CRC_INIT;
    for (int i = 0; i < rfd_pkg::HCRC_SPAN; i++) hcrc = crc32c_next(hcrc, hb[i]);
    hcrc ^= rfd_pkg::CRC_INIT;
    if (hcrc_bad) hcrc ^= 32'd1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) hb[rfd_pkg::OFS_HCRC + i] = hcrc[8*i +: 8];
    for (int i = 0; i < rfd_pkg::HDR_SIZE && i < int'(sent); i++) push_beat(1'b0, hb[i]);
    foreach (body[i]) push_beat(1'b0, body[i]);
  endtask

  function automatic logic [15:0] pick_type();
    logic [15:0] t;
    t = 16'($urandom_range(0, 15));
    if (cfg_types != 16'd0)
      while (!cfg_types[t[3:0]]) t = 16'($urandom_range(0, 15));
    return t;
  endfunction

  function automatic logic [31:0] pick_len();
    return (cfg_maxlen < 32'd24) ? $urandom_range(0, cfg_maxlen) : $urandom_range(0, 24);
  endfunction

  task automatic push_good(input logic [31:0] plen, input bit pcrc_bad, input int unsigned sent);
    push_record(cfg_magic, cfg_version, pick_type(), plen, {$urandom, $urandom}, pcrc_bad,
                1'b0, sent);
    if (cfg_types == 16'd0 || sent < 32'(rfd_pkg::HDR_SIZE) + plen) push_end();
  endtask

  task automatic push_flawed();
    logic [31:0] magic;
    logic [31:0] plen;
    logic [15:0] ver;
    logic [15:0] t;
    bit          hbad;
    magic = cfg_magic;
    ver = cfg_version;
    t = pick_type();
    plen = pick_len();
    hbad = 1'b0;
    case ($urandom_range(0, 4))
      0: magic ^= 32'd1 << $urandom_range(0, 31);
      1: ver ^= 16'd1 << $urandom_range(0, 15);
      2: t = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16, 65535)) :
             16'($urandom_range(0, 15));
      3: plen = (cfg_maxlen == '1) ? '1 : cfg_maxlen + 32'd1 + $urandom_range(0, 3);
      default: hbad = 1'b1;
    endcase
    push_record(magic, ver, t, plen, {$urandom, $urandom}, 1'b0, hbad,
                32'(rfd_pkg::HDR_SIZE) + $urandom_range(0, 6));
    push_end();
  endtask

  task automatic random_record();
    logic [31:0] plen;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      plen = pick_len();
      push_good(plen, $urandom_range(0, 9) == 0, 32'(rfd_pkg::HDR_SIZE) + plen);
    end else if (r < 77) begin
      push_flawed();
    end else if (r < 84) begin
      plen = pick_len();
      push_good(plen, 1'b0, $urandom_range(1, 32'(rfd_pkg::HDR_SIZE) + plen - 32'd1));
    end else if (r < 89) begin
      push_end();
    end else if (r < 94) begin
      push_record(cfg_magic, cfg_version, pick_type(), $urandom | 32'h100, {$urandom, $urandom},
                  1'b0, 1'b0, 32'(rfd_pkg::HDR_SIZE) + $urandom_range(0, 10));
      push_end();
    end else begin
      repeat ($urandom_range(1, 40)) push_beat(1'b0, 8'($urandom_range(0, 255)));
      push_end();
    end
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [15:0] ver,
                            input logic [15:0] types, input logic [31:0] maxlen);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= rfd_pkg::REG_MAGIC;
    cfg_data <= magic;
    cfg_magic = magic;
    @(posedge clk);
    cfg_index <= rfd_pkg::REG_VERSION;
    cfg_data <= {16'h0, ver};
    cfg_version = ver;
    @(posedge clk);
    cfg_index <= rfd_pkg::REG_TYPES;
    cfg_data <= {16'h0, types};
    cfg_types = types;
    @(posedge clk);
    cfg_index <= rfd_pkg::REG_MAXLEN;
    cfg_data <= maxlen;
    cfg_maxlen = maxlen;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [31:0] magic;
    logic [31:0] maxlen;
    logic [15:0] ver;
    logic [15:0] types;
    case ($urandom_range(0, 3))
      0: magic = '0;
      1: magic = '1;
      default: magic = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: ver = '0;
      1: ver = '1;
      default: ver = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0, 1: types = 16'hFFFF;
      2: types = 16'd1 << $urandom_range(0, 15);
      default: types = 16'($urandom | $urandom);
    endcase
    case ($urandom_range(0, 4))
      0: maxlen = '1;
      1: maxlen = '0;
      2: maxlen = $urandom;
      default: maxlen = $urandom_range(0, 40);
    endcase
    set_config(magic, ver, types, maxlen);
  endtask

  // hold until all beats are taken and every predicted result has arrived
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while (stream_beats.size() != 0 || s_axis_tvalid) @(negedge clk);
    while (decoded_beats.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
    if (decoded_beats.size() != 0) begin
      report("results never delivered", 128'(decoded_beats.size()), 128'd0);
      decoded_beats.delete();
    end
  endtask

  initial begin
    int unsigned first;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_end();
    push_good(3, 1'b0, 32'(rfd_pkg::HDR_SIZE) + 32'd3);
    push_record(32'h0, 16'd1, 16'd0, 32'd0, 64'h0, 1'b0, 1'b0, rfd_pkg::HDR_SIZE);
    push_record(32'h0, 16'd1, 16'd15, 32'd0, '1, 1'b1, 1'b0, rfd_pkg::HDR_SIZE);
    push_record(32'h0, 16'd1, 16'd7, 32'd2, {$urandom, $urandom}, 1'b1, 1'b0,
                rfd_pkg::HDR_SIZE + 2);
    push_record(32'h1, 16'd1, 16'd0, 32'd4, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE + 4);
    push_end();
    push_record(32'h0, 16'd0, 16'd3, 32'd1, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE + 1);
    push_end();
    push_record(32'h0, 16'd1, 16'd16, 32'd0, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE);
    push_end();
    push_record(32'h0, 16'd1, 16'hFFFF, 32'd0, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE);
    push_end();
    push_record(32'h0, 16'd1, 16'd2, 32'd3, {$urandom, $urandom}, 1'b0, 1'b1,
                rfd_pkg::HDR_SIZE + 3);
    push_end();
    push_record(32'h0, 16'd1, 16'd2, 32'd3, {$urandom, $urandom}, 1'b0, 1'b0, 5);
    push_end();
    push_record(32'h0, 16'd1, 16'd9, 32'd10, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE + 5);
    push_end();
    push_record(32'h0, 16'd1, 16'd1, '1, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE + 3);
    push_end();
    wait_drained();

    set_config('1, '1, 16'h8001, '0);
    push_record('1, '1, 16'd15, 32'd0, {$urandom, $urandom}, 1'b0, 1'b0, rfd_pkg::HDR_SIZE);
    push_record('1, '1, 16'd0, 32'd1, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE + 1);
    push_end();
    push_record('1, '1, 16'd1, 32'd5, {$urandom, $urandom}, 1'b0, 1'b0, rfd_pkg::HDR_SIZE);
    push_end();
    push_record('1, '1, 16'd0, 32'd1, {$urandom, $urandom}, 1'b0, 1'b1, rfd_pkg::HDR_SIZE);
    push_end();
    push_record(32'h0, 16'h0, 16'd16, 32'd0, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE);
    push_end();
    push_record('1, 16'h0, 16'd16, 32'd0, {$urandom, $urandom}, 1'b0, 1'b0,
                rfd_pkg::HDR_SIZE);
    push_end();
    wait_drained();

    set_config('0, '0, '0, '1);
    push_good(2, 1'b0, 32'(rfd_pkg::HDR_SIZE) + 32'd2);
    push_end();
    wait_drained();

    repeat (6) begin
      random_config();
      first = beats_queued;
      while (beats_queued - first < 135) random_record();
      push_end();
      wait_drained();
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rfd_pkg.sv
rtl/core/record_frame_decoder.sv
sim/tb_top.sv
